[hw/rtl/psm_pkg.sv]
package psm_pkg;

	localparam int WORD_BITS   = 32;
	localparam int STACK_DEPTH = 512;
	localparam int SAW         = $clog2(STACK_DEPTH);
	localparam int PC_W        = 11;
	localparam int ARG_W       = 11;
	localparam int LEV_W       = 2;
	localparam int MAX_LEVEL   = 3;
	localparam int SUM_W       = ((SAW > ARG_W) ? SAW : ARG_W) + 1;
	localparam int INIT_CELLS  = 4;
	localparam int INIT_W      = $clog2(INIT_CELLS);

	typedef logic [WORD_BITS-1:0] word_t;

	localparam logic [2:0] FC_LIT = 3'd0;
	localparam logic [2:0] FC_OPR = 3'd1;
	localparam logic [2:0] FC_LOD = 3'd2;
	localparam logic [2:0] FC_STO = 3'd3;
	localparam logic [2:0] FC_CAL = 3'd4;
	localparam logic [2:0] FC_INT = 3'd5;
	localparam logic [2:0] FC_JMP = 3'd6;
	localparam logic [2:0] FC_JPC = 3'd7;

	localparam logic [ARG_W-1:0] OP_RET = 11'd0;
	localparam logic [ARG_W-1:0] OP_NEG = 11'd1;
	localparam logic [ARG_W-1:0] OP_ADD = 11'd2;
	localparam logic [ARG_W-1:0] OP_SUB = 11'd3;
	localparam logic [ARG_W-1:0] OP_MUL = 11'd4;
	localparam logic [ARG_W-1:0] OP_DIV = 11'd5;
	localparam logic [ARG_W-1:0] OP_REM = 11'd6;
	localparam logic [ARG_W-1:0] OP_EQ  = 11'd8;
	localparam logic [ARG_W-1:0] OP_NE  = 11'd9;
	localparam logic [ARG_W-1:0] OP_LT  = 11'd10;
	localparam logic [ARG_W-1:0] OP_LE  = 11'd11;
	localparam logic [ARG_W-1:0] OP_GT  = 11'd12;
	localparam logic [ARG_W-1:0] OP_GE  = 11'd13;

	localparam logic [1:0] FAULT_NONE   = 2'd0;
	localparam logic [1:0] FAULT_DIV    = 2'd1;
	localparam logic [1:0] FAULT_BOUNDS = 2'd2;

	typedef struct packed {
		logic [2:0]       function_code;
		logic [LEV_W-1:0] level;
		logic [ARG_W-1:0] argument;
	} in_item_t;

	typedef struct packed {
		logic [PC_W-1:0]             next_pc;
		logic signed [WORD_BITS-1:0] top_value;
		logic [SAW-1:0]              top_index;
		logic                        halted;
		logic [1:0]                  fault;
	} out_item_t;

	typedef enum logic [2:0] {
		RS_TOP, RS_TOPM1, RS_WB, RS_ADDR, RS_BASE1, RS_BASE2
	} rd_sel_t;

	typedef enum logic [2:0] {
		WA_TOP, WA_TOPM1, WA_TOPP1, WA_TOPP2, WA_TOPP3, WA_ADDR
	} wr_sel_t;

	typedef enum logic [2:0] {
		WD_RES, WD_RD, WD_ARG, WD_WB, WD_BASE, WD_NEXT
	} wd_sel_t;

	typedef enum logic [2:0] {
		T_KEEP, T_INC, T_DEC, T_ADDARG, T_BASEM1
	} top_upd_t;

	typedef enum logic [1:0] {
		B_KEEP, B_TOPP1, B_DYN
	} base_upd_t;

	typedef enum logic [1:0] {
		N_KEEP, N_ARG, N_RET
	} next_upd_t;

	typedef struct packed {
		logic      accept;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      cap_x;
		logic      cap_y;
		logic      walk_step;
		logic      alu;
		logic      div_start;
		logic      wr_en;
		wr_sel_t   wr_sel;
		wd_sel_t   wd_sel;
		top_upd_t  top_upd;
		base_upd_t base_upd;
		next_upd_t next_upd;
		logic      fault_set;
		logic [1:0] fault_code;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] fc;
		logic op_ret;
		logic op_unary;
		logic op_binary;
		logic op_div;
		logic t_full;
		logic t_zero;
		logic cal_bad;
		logic base_bad;
		logic link_bad;
		logic dyn_bad;
		logic addr_bad;
		logic alloc_bad;
		logic cnt_zero;
		logic div_zero;
		logic div_busy;
		logic rd_zero;
		logic out_busy;
	} stat_t;

endpackage

[hw/rtl/psm_div.sv]
module psm_div import psm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t dividend,
	input  word_t divisor,
	output logic  busy,
	output word_t quotient
);

	localparam int CNT_W = $clog2(WORD_BITS + 1);

	logic [CNT_W-1:0]   cnt_q;
	word_t              rem_q;
	word_t              quo_q;
	word_t              mb_q;
	logic               neg_q;
	logic [WORD_BITS:0] shifted;
	logic [WORD_BITS:0] trial;

	assign shifted  = {rem_q, quo_q[WORD_BITS-1]};
	assign trial    = shifted - {1'b0, mb_q};
	assign busy     = (cnt_q != '0);
	assign quotient = neg_q ? (word_t'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(WORD_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Restoring division on magnitudes, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[WORD_BITS-1] ? (word_t'(0) - dividend) : dividend;
			mb_q  <= divisor[WORD_BITS-1] ? (word_t'(0) - divisor) : divisor;
			rem_q <= '0;
			neg_q <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
		end else if (busy) begin
			if (!trial[WORD_BITS]) begin
				rem_q <= trial[WORD_BITS-1:0];
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_BITS-1:0];
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

endmodule

[hw/rtl/psm_dp.sv]
module psm_dp import psm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  cmd_t      cmd,
	output stat_t     st,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_data
);

	word_t mem [STACK_DEPTH];
	word_t rd_raw_q;
	logic  rd_low_q;
	logic [INIT_CELLS-1:0] init_vld_q;

	logic [2:0]       fc_q;
	logic [ARG_W-1:0] arg_q;
	logic [LEV_W-1:0] cnt_q;
	logic [SAW-1:0]   wb_q;
	logic [PC_W-1:0]  pc_q;
	logic [PC_W-1:0]  next_q;
	logic [SAW-1:0]   base_q;
	logic [SAW-1:0]   top_q;
	logic [1:0]       fault_q;
	word_t            x_q;
	word_t            y_q;
	word_t            res_q;
	logic             out_valid_q;
	out_item_t        out_q;

	word_t          rdata;
	word_t          alu_res;
	word_t          wd;
	word_t          quotient;
	logic           div_busy;
	logic [SAW-1:0] ra;
	logic [SAW-1:0] wa;
	logic [SUM_W-1:0] addr_sum;
	logic [SUM_W-1:0] alloc_sum;
	logic [SAW:0]     top_ext;
	logic [SAW:0]     base_ext;

	assign rdata     = rd_low_q ? '0 : rd_raw_q;
	assign addr_sum  = SUM_W'(wb_q) + SUM_W'(arg_q);
	assign alloc_sum = SUM_W'(top_q) + SUM_W'(arg_q);
	assign top_ext   = {1'b0, top_q};
	assign base_ext  = {1'b0, base_q};

	psm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (x_q),
		.divisor  (y_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		st           = '0;
		st.fc        = fc_q;
		st.op_ret    = (arg_q == OP_RET);
		st.op_unary  = (arg_q == OP_NEG) || (arg_q == OP_REM);
		st.op_binary = ((arg_q >= OP_ADD) && (arg_q <= OP_DIV))
			|| ((arg_q >= OP_EQ) && (arg_q <= OP_GE));
		st.op_div    = (arg_q == OP_DIV);
		st.t_full    = (top_q == SAW'(STACK_DEPTH - 1));
		st.t_zero    = (top_q == '0);
		st.cal_bad   = (top_ext + (SAW+1)'(3)) >= (SAW+1)'(STACK_DEPTH);
		st.base_bad  = (base_q == '0) || ((base_ext + (SAW+1)'(2)) >= (SAW+1)'(STACK_DEPTH));
		st.link_bad  = (rdata[WORD_BITS-1:SAW] != '0);
		st.dyn_bad   = (x_q[WORD_BITS-1:SAW] != '0);
		st.addr_bad  = addr_sum >= SUM_W'(STACK_DEPTH);
		st.alloc_bad = alloc_sum >= SUM_W'(STACK_DEPTH);
		st.cnt_zero  = (cnt_q == '0);
		st.div_zero  = (y_q == '0);
		st.div_busy  = div_busy;
		st.rd_zero   = (rdata == '0);
		st.out_busy  = out_valid_q && !out_ready;
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RS_TOP:   ra = top_q;
			RS_TOPM1: ra = top_q - SAW'(1);
			RS_WB:    ra = wb_q;
			RS_ADDR:  ra = addr_sum[SAW-1:0];
			RS_BASE1: ra = base_q + SAW'(1);
			RS_BASE2: ra = base_q + SAW'(2);
			default:  ra = top_q;
		endcase
		unique case (cmd.wr_sel)
			WA_TOP:   wa = top_q;
			WA_TOPM1: wa = top_q - SAW'(1);
			WA_TOPP1: wa = top_q + SAW'(1);
			WA_TOPP2: wa = top_q + SAW'(2);
			WA_TOPP3: wa = top_q + SAW'(3);
			WA_ADDR:  wa = addr_sum[SAW-1:0];
			default:  wa = top_q;
		endcase
		unique case (cmd.wd_sel)
			WD_RES:  wd = res_q;
			WD_RD:   wd = rdata;
			WD_ARG:  wd = word_t'(arg_q);
			WD_WB:   wd = word_t'(wb_q);
			WD_BASE: wd = word_t'(base_q);
			WD_NEXT: wd = word_t'(next_q);
			default: wd = res_q;
		endcase
	end

	// Unary operations work on y, the word at the top.
	always_comb begin
		case (arg_q)
			OP_NEG:  alu_res = word_t'(0) - y_q;
			OP_ADD:  alu_res = x_q + y_q;
			OP_SUB:  alu_res = x_q - y_q;
			OP_MUL:  alu_res = x_q * y_q;
			OP_DIV:  alu_res = quotient;
			OP_REM:  alu_res = !y_q[0] ? '0 : (y_q[WORD_BITS-1] ? '1 : word_t'(1));
			OP_EQ:   alu_res = word_t'(x_q == y_q);
			OP_NE:   alu_res = word_t'(x_q != y_q);
			OP_LT:   alu_res = word_t'($signed(x_q) < $signed(y_q));
			OP_LE:   alu_res = word_t'($signed(x_q) <= $signed(y_q));
			OP_GT:   alu_res = word_t'($signed(x_q) > $signed(y_q));
			default: alu_res = word_t'($signed(x_q) >= $signed(y_q));
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rd_raw_q <= mem[ra];
		end
	end

	// The first frame cells read as zero until they are written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_vld_q <= '0;
			rd_low_q   <= 1'b0;
		end else begin
			if (cmd.wr_en && (wa < SAW'(INIT_CELLS))) begin
				init_vld_q[wa[INIT_W-1:0]] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_low_q <= (ra < SAW'(INIT_CELLS)) && !init_vld_q[ra[INIT_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			base_q      <= SAW'(1);
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.top_upd)
				T_INC:    top_q <= top_q + SAW'(1);
				T_DEC:    top_q <= top_q - SAW'(1);
				T_ADDARG: top_q <= alloc_sum[SAW-1:0];
				T_BASEM1: top_q <= base_q - SAW'(1);
				default:  top_q <= top_q;
			endcase
			unique case (cmd.base_upd)
				B_TOPP1: base_q <= top_q + SAW'(1);
				B_DYN:   base_q <= x_q[SAW-1:0];
				default: base_q <= base_q;
			endcase
			if (cmd.out_load) begin
				pc_q        <= next_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fc_q    <= in_data.function_code;
			arg_q   <= in_data.argument;
			cnt_q   <= (in_data.level > LEV_W'(MAX_LEVEL)) ? LEV_W'(MAX_LEVEL) : in_data.level;
			wb_q    <= base_q;
			next_q  <= pc_q + PC_W'(1);
			fault_q <= FAULT_NONE;
		end else begin
			if (cmd.walk_step) begin
				wb_q  <= rdata[SAW-1:0];
				cnt_q <= cnt_q - LEV_W'(1);
			end
			unique case (cmd.next_upd)
				N_ARG:   next_q <= arg_q;
				N_RET:   next_q <= rdata[PC_W-1:0];
				default: next_q <= next_q;
			endcase
			if (cmd.fault_set) begin
				fault_q <= cmd.fault_code;
			end
		end
		if (cmd.cap_x) begin
			x_q <= rdata;
		end
		if (cmd.cap_y) begin
			y_q <= rdata;
		end
		if (cmd.alu) begin
			res_q <= alu_res;
		end
		if (cmd.out_load) begin
			out_q.next_pc   <= next_q;
			out_q.top_value <= $signed(rdata);
			out_q.top_index <= top_q;
			out_q.halted    <= (next_q == '0);
			out_q.fault     <= fault_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/psm_ctrl.sv]
module psm_ctrl import psm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [14:0] {
		S_IDLE     = 15'h0001,
		S_DECODE   = 15'h0002,
		S_WALK     = 15'h0004,
		S_WALK_UPD = 15'h0008,
		S_RET_A    = 15'h0010,
		S_RET_B    = 15'h0020,
		S_RD_T     = 15'h0040,
		S_DATA     = 15'h0080,
		S_ALU      = 15'h0100,
		S_DIV      = 15'h0200,
		S_WR_ALU   = 15'h0400,
		S_CAL2     = 15'h0800,
		S_CAL3     = 15'h1000,
		S_RDTOP    = 15'h2000,
		S_OUT      = 15'h4000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Every bounds check comes before the first write, so a faulting step
	// leaves the stack, top and base as they were.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RDTOP;
				case (st.fc)
					FC_LIT: begin
						if (st.t_full) begin
							cmd.fault_set  = 1'b1;
							cmd.fault_code = FAULT_BOUNDS;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = WA_TOPP1;
							cmd.wd_sel  = WD_ARG;
							cmd.top_upd = T_INC;
						end
					end
					FC_OPR: begin
						if (st.op_ret) begin
							if (st.base_bad) begin
								cmd.fault_set  = 1'b1;
								cmd.fault_code = FAULT_BOUNDS;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RS_BASE1;
								state_d    = S_RET_A;
							end
						end else if (st.op_unary) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RS_TOP;
							state_d    = S_DATA;
						end else if (st.op_binary) begin
							if (st.t_zero) begin
								cmd.fault_set  = 1'b1;
								cmd.fault_code = FAULT_BOUNDS;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RS_TOPM1;
								state_d    = S_RD_T;
							end
						end
					end
					FC_LOD: state_d = S_WALK;
					FC_STO, FC_CAL: begin
						if ((st.fc == FC_STO && st.t_zero) || (st.fc == FC_CAL && st.cal_bad)) begin
							cmd.fault_set  = 1'b1;
							cmd.fault_code = FAULT_BOUNDS;
						end else begin
							state_d = S_WALK;
						end
					end
					FC_INT: begin
						if (st.alloc_bad) begin
							cmd.fault_set  = 1'b1;
							cmd.fault_code = FAULT_BOUNDS;
						end else begin
							cmd.top_upd = T_ADDARG;
						end
					end
					FC_JMP: cmd.next_upd = N_ARG;
					default: begin
						if (st.t_zero) begin
							cmd.fault_set  = 1'b1;
							cmd.fault_code = FAULT_BOUNDS;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RS_TOP;
							state_d    = S_DATA;
						end
					end
				endcase
			end
			S_WALK: begin
				if (!st.cnt_zero) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RS_WB;
					state_d    = S_WALK_UPD;
				end else begin
					case (st.fc)
						FC_LOD, FC_STO: begin
							if (st.addr_bad || (st.fc == FC_LOD && st.t_full)) begin
								cmd.fault_set  = 1'b1;
								cmd.fault_code = FAULT_BOUNDS;
								state_d        = S_RDTOP;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = (st.fc == FC_LOD) ? RS_ADDR : RS_TOP;
								state_d    = S_DATA;
							end
						end
						default: begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WA_TOPP1;
							cmd.wd_sel = WD_WB;
							state_d    = S_CAL2;
						end
					endcase
				end
			end
			S_WALK_UPD: begin
				if (st.link_bad) begin
					cmd.fault_set  = 1'b1;
					cmd.fault_code = FAULT_BOUNDS;
					state_d        = S_RDTOP;
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_RET_A: begin
				cmd.cap_x  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RS_BASE2;
				state_d    = S_RET_B;
			end
			S_RET_B: begin
				if (st.dyn_bad) begin
					cmd.fault_set  = 1'b1;
					cmd.fault_code = FAULT_BOUNDS;
				end else begin
					cmd.top_upd  = T_BASEM1;
					cmd.base_upd = B_DYN;
					cmd.next_upd = N_RET;
				end
				state_d = S_RDTOP;
			end
			S_RD_T: begin
				cmd.cap_x  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RS_TOP;
				state_d    = S_DATA;
			end
			S_DATA: begin
				state_d = S_RDTOP;
				case (st.fc)
					FC_LOD: begin
						cmd.wr_en   = 1'b1;
						cmd.wr_sel  = WA_TOPP1;
						cmd.wd_sel  = WD_RD;
						cmd.top_upd = T_INC;
					end
					FC_STO: begin
						cmd.wr_en   = 1'b1;
						cmd.wr_sel  = WA_ADDR;
						cmd.wd_sel  = WD_RD;
						cmd.top_upd = T_DEC;
					end
					FC_JPC: begin
						if (st.rd_zero) begin
							cmd.next_upd = N_ARG;
						end
						cmd.top_upd = T_DEC;
					end
					default: begin
						cmd.cap_y = 1'b1;
						state_d   = S_ALU;
					end
				endcase
			end
			S_ALU: begin
				if (st.op_div) begin
					if (st.div_zero) begin
						cmd.fault_set  = 1'b1;
						cmd.fault_code = FAULT_DIV;
						state_d        = S_RDTOP;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end else begin
					cmd.alu = 1'b1;
					state_d = S_WR_ALU;
				end
			end
			S_DIV: begin
				if (!st.div_busy) begin
					cmd.alu = 1'b1;
					state_d = S_WR_ALU;
				end
			end
			S_WR_ALU: begin
				cmd.wr_en  = 1'b1;
				cmd.wd_sel = WD_RES;
				if (st.op_unary) begin
					cmd.wr_sel = WA_TOP;
				end else begin
					cmd.wr_sel  = WA_TOPM1;
					cmd.top_upd = T_DEC;
				end
				state_d = S_RDTOP;
			end
			S_CAL2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WA_TOPP2;
				cmd.wd_sel = WD_BASE;
				state_d    = S_CAL3;
			end
			S_CAL3: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = WA_TOPP3;
				cmd.wd_sel   = WD_NEXT;
				cmd.base_upd = B_TOPP1;
				cmd.next_upd = N_ARG;
				state_d      = S_RDTOP;
			end
			S_RDTOP: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RS_TOP;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hw/rtl/pcode_stack_machine_step.sv]
// Executes one stack machine instruction per input beat and returns one result beat.
// The time to a valid result depends on the instruction: a call adds a static-link walk of up to
// three levels, and a divide is set by the one-bit-per-cycle divider and the single stack port.
// One instruction is in flight at a time; the next is taken the cycle after the result is
// registered, which waits while the previous result stalls.
// Reset (asynchronous, active low): pc 0, base 1, top 0, first frame cells read as zero.
module pcode_stack_machine_step import psm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	cmd_t  cmd;
	stat_t st;

	psm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	psm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// The stack memory has a single port.
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("stack read and write in the same cycle");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while an instruction is in flight");

	a_halt_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.halted == (out_data.next_pc == '0)))
		else $error("halt flag disagrees with next pc");

	a_div_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fault_set && cmd.fault_code == FAULT_DIV) |-> (st.op_div && st.div_zero))
		else $error("divide fault without a zero divisor");

endmodule
